>>> hdl/qte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types and constants of the quartic trajectory evaluator.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int FIELD_W    = 32;
    localparam int TIME_W     = 24;
    localparam int ACC_W      = 64;
    localparam int COEF_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_TERMS  = 5;
    localparam int NUM_STEPS  = NUM_TERMS - 1;
    localparam int NUM_STAGES = 2 * NUM_STEPS + 1;
    localparam int NUM_LANES  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_START_POSITION     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_VELOCITY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_ACCELERATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_VELOCITY       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_ACCELERATION   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION           = 3'd5;

    localparam logic [TIME_W-1:0] DURATION_RESET = 24'd65536;

    localparam logic [ACC_W-1:0]  MAG_MAX   = 64'h7fff_ffff_ffff_ffff;
    localparam logic [ACC_W-1:0]  ACC_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [COEF_W-1:0] COEF_MAX  = 48'h7fff_ffff_ffff;

    typedef logic [NUM_TERMS-1:0][ACC_W-1:0] coef_set_t;
    typedef logic [NUM_STAGES-1:0]           stage_en_t;

    typedef struct packed {
        logic                     ready;
        logic signed [COEF_W-1:0] c3;
        logic signed [COEF_W-1:0] c4;
    } coef_state_t;

    function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] a);
        mag64 = a[ACC_W-1] ? (~a + 64'd1) : a;
    endfunction

endpackage
`default_nettype wire

>>> hdl/quartic_trajectory_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quartic_trajectory_evaluator
// Quartic motion profile: position, velocity, acceleration and jerk at t.
// ----------------------------------------------------------------------------
// One sample time is taken per cycle unless the pipeline stalls or the
// coefficients are not yet solved, and passes through the nine-stage evaluation
// pipeline (four Horner steps of two stages each plus a rounding stage), all
// four derivatives in parallel lanes. A stalled output holds its transaction
// while free stages behind it keep filling. After any register write, and
// after reset, the coefficient solver runs (one quotient bit per cycle
// through a shared divider); sample times are held off during that time
// unless the duration is zero.
module quartic_trajectory_evaluator #(
    parameter int FRACTION_BITS = 16,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [qte_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [qte_pkg::FIELD_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [qte_pkg::TIME_W-1:0]            sample_time,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [qte_pkg::FIELD_W-1:0]    position,
    output logic signed [qte_pkg::FIELD_W-1:0]    velocity,
    output logic signed [qte_pkg::FIELD_W-1:0]    acceleration,
    output logic signed [qte_pkg::FIELD_W-1:0]    jerk,
    output logic                                  saturated,
    output logic                                  invalid_duration
);
    import qte_pkg::*;

    logic signed [FIELD_W-1:0] start_position_reg;
    logic signed [FIELD_W-1:0] start_velocity_reg;
    logic signed [FIELD_W-1:0] start_acceleration_reg;
    logic signed [FIELD_W-1:0] end_velocity_reg;
    logic signed [FIELD_W-1:0] end_acceleration_reg;
    logic [TIME_W-1:0]         duration_reg;
    logic                      cfg_touch;

    assign cfg_touch = cfg_write && (cfg_index <= REG_DURATION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_position_reg     <= '0;
            start_velocity_reg     <= '0;
            start_acceleration_reg <= '0;
            end_velocity_reg       <= '0;
            end_acceleration_reg   <= '0;
            duration_reg           <= DURATION_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_POSITION:     start_position_reg     <= $signed(cfg_data);
                REG_START_VELOCITY:     start_velocity_reg     <= $signed(cfg_data);
                REG_START_ACCELERATION: start_acceleration_reg <= $signed(cfg_data);
                REG_END_VELOCITY:       end_velocity_reg       <= $signed(cfg_data);
                REG_END_ACCELERATION:   end_acceleration_reg   <= $signed(cfg_data);
                REG_DURATION:           duration_reg           <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    coef_state_t coef;

    qte_coef_solver #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_solver (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_touch         (cfg_touch),
        .start_velocity    (start_velocity_reg),
        .start_acceleration(start_acceleration_reg),
        .end_velocity      (end_velocity_reg),
        .end_acceleration  (end_acceleration_reg),
        .duration          (duration_reg),
        .coef              (coef)
    );

    // coefficient sets, leading zeros pad the shorter derivatives
    logic signed [ACC_W-1:0] c0, c1, c2x2, c3, c4;
    coef_set_t               lane_coef [NUM_LANES];

    assign c0   = ACC_W'(start_position_reg) <<< FRACTION_BITS;
    assign c1   = ACC_W'(start_velocity_reg) <<< FRACTION_BITS;
    assign c2x2 = ACC_W'(start_acceleration_reg) <<< FRACTION_BITS;
    assign c3   = ACC_W'(coef.c3);
    assign c4   = ACC_W'(coef.c4);

    // index 0 is the first Horner term
    always_comb
    begin
        lane_coef[0] = {c0, c1, ACC_W'(start_acceleration_reg) <<< (FRACTION_BITS - 1),
                        c3, c4};
        lane_coef[1] = {c1, c2x2, c3 * ACC_W'(3), c4 * ACC_W'(4), ACC_W'(0)};
        lane_coef[2] = {c2x2, c3 * ACC_W'(6), c4 * ACC_W'(12), ACC_W'(0), ACC_W'(0)};
        lane_coef[3] = {c3 * ACC_W'(6), c4 * ACC_W'(24), ACC_W'(0), ACC_W'(0), ACC_W'(0)};
    end

    // stage valid bits and per-stage advance
    stage_en_t v_reg;
    stage_en_t en;

    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0] && (coef.ready || duration_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid && in_ready;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    logic [FIELD_W-1:0] lane_value [NUM_LANES];
    logic               lane_sat   [NUM_LANES];

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        qte_lane #(
            .FRACTION_BITS(FRACTION_BITS),
            .VALUE_WIDTH  (VALUE_WIDTH)
        ) u_lane (
            .clk        (clk),
            .en         (en),
            .sample_time(sample_time),
            .coefs      (lane_coef[i]),
            .value      (lane_value[i]),
            .saturated  (lane_sat[i])
        );
    end

    logic zero_dur;

    assign zero_dur         = duration_reg == '0;
    assign out_valid        = v_reg[NUM_STAGES-1];
    assign position         = zero_dur ? '0 : $signed(lane_value[0]);
    assign velocity         = zero_dur ? '0 : $signed(lane_value[1]);
    assign acceleration     = zero_dur ? '0 : $signed(lane_value[2]);
    assign jerk             = zero_dur ? '0 : $signed(lane_value[3]);
    assign saturated        = !zero_dur &&
                              (lane_sat[0] || lane_sat[1] || lane_sat[2] || lane_sat[3]);
    assign invalid_duration = zero_dur;

    a_ready_needs_coef: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && !zero_dur) |-> coef.ready)
        else $error("sample accepted before coefficients solved");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted transaction missing from first stage");

    a_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_touch |=> !coef.ready)
        else $error("coefficients still marked ready after register write");

endmodule
`default_nettype wire

>>> hdl/qte_coef_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_coef_solver
// Solves the cubic and quartic coefficients from the boundary registers with
// a bit-serial restoring divider shared by both quotients.
// ----------------------------------------------------------------------------
module qte_coef_solver #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_touch,
    input  logic signed [qte_pkg::FIELD_W-1:0]   start_velocity,
    input  logic signed [qte_pkg::FIELD_W-1:0]   start_acceleration,
    input  logic signed [qte_pkg::FIELD_W-1:0]   end_velocity,
    input  logic signed [qte_pkg::FIELD_W-1:0]   end_acceleration,
    input  logic        [qte_pkg::TIME_W-1:0]    duration,
    output qte_pkg::coef_state_t                 coef
);
    import qte_pkg::*;

    localparam int DIV_W = 76;
    localparam int CNT_W = 8;
    localparam int T2_W  = 2 * TIME_W;
    localparam int T3_W  = 3 * TIME_W;
    localparam logic [CNT_W-1:0] SH3 = CNT_W'(2 * FRACTION_BITS);
    localparam logic [CNT_W-1:0] SH4 = CNT_W'(3 * FRACTION_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_NUM  = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_RND  = 3'd6;

    logic [2:0]               state_reg;
    logic                     ready_reg;
    logic                     sel_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [COEF_W-1:0] c3_reg;
    logic signed [COEF_W-1:0] c4_reg;

    logic signed [FIELD_W:0]  b1_reg;
    logic signed [ACC_W-1:0]  dv_reg;
    logic signed [ACC_W-1:0]  at_reg;
    logic signed [ACC_W-1:0]  tb_reg;
    logic signed [ACC_W-1:0]  b0_reg;
    logic signed [ACC_W-1:0]  n3_reg;
    logic signed [ACC_W-1:0]  n4_reg;
    logic [T2_W-1:0]          t2_reg;
    logic [T3_W-1:0]          t3_reg;
    logic [DIV_W-1:0]         d3_reg;
    logic [DIV_W-1:0]         d4_reg;
    logic [ACC_W-1:0]         num_reg;
    logic                     neg_reg;
    logic [DIV_W-1:0]         div_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [COEF_W-1:0]        q_reg;
    logic                     ovf_reg;

    logic [CNT_W-1:0]         sh_cur;
    logic                     feed;
    logic                     din;
    logic [DIV_W-1:0]         rem_sh;
    logic                     ge;
    logic                     rnd_up;
    logic [COEF_W:0]          q_rnd;
    logic [COEF_W-1:0]        q_mag;
    logic signed [COEF_W-1:0] q_signed;

    assign sh_cur   = sel_reg ? SH4 : SH3;
    assign feed     = cnt_reg >= sh_cur;
    assign din      = feed & num_reg[ACC_W-1];
    assign rem_sh   = {rem_reg[DIV_W-2:0], din};
    assign ge       = rem_sh >= div_reg;
    assign rnd_up   = {rem_reg[DIV_W-2:0], 1'b0} >= div_reg;
    assign q_rnd    = {1'b0, q_reg} + {{COEF_W{1'b0}}, rnd_up};
    assign q_mag    = (ovf_reg || q_rnd > {1'b0, COEF_MAX}) ? COEF_MAX : q_rnd[COEF_W-1:0];
    assign q_signed = neg_reg ? $signed(~q_mag + 48'd1) : $signed(q_mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
            sel_reg   <= 1'b0;
            cnt_reg   <= '0;
            c3_reg    <= '0;
            c4_reg    <= '0;
        end
        else if (cfg_touch)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!ready_reg && duration != '0)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:  state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_NUM;
                ST_NUM:
                begin
                    sel_reg   <= 1'b0;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    cnt_reg   <= CNT_W'(63) + sh_cur;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_RND;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_RND:
                begin
                    if (!sel_reg)
                    begin
                        c3_reg    <= q_signed;
                        sel_reg   <= 1'b1;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        c4_reg    <= q_signed;
                        ready_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_MUL:
            begin
                b1_reg <= (FIELD_W + 1)'(end_acceleration) - (FIELD_W + 1)'(start_acceleration);
                dv_reg <= (ACC_W'(end_velocity) - ACC_W'(start_velocity)) <<< FRACTION_BITS;
                at_reg <= ACC_W'(start_acceleration * $signed({1'b0, duration}));
                t2_reg <= duration * duration;
            end
            ST_MUL2:
            begin
                tb_reg <= ACC_W'(b1_reg * $signed({1'b0, duration}));
                b0_reg <= dv_reg - at_reg;
                t3_reg <= t2_reg * duration;
            end
            ST_NUM:
            begin
                n3_reg <= b0_reg * ACC_W'(3) - tb_reg;
                n4_reg <= tb_reg - (b0_reg <<< 1);
                d3_reg <= DIV_W'(t2_reg) * DIV_W'(3);
                d4_reg <= DIV_W'({t3_reg, 2'b00});
            end
            ST_LOAD:
            begin
                num_reg <= mag64(sel_reg ? n4_reg : n3_reg);
                neg_reg <= sel_reg ? n4_reg[ACC_W-1] : n3_reg[ACC_W-1];
                div_reg <= sel_reg ? d4_reg : d3_reg;
                rem_reg <= '0;
                q_reg   <= '0;
                ovf_reg <= 1'b0;
            end
            ST_DIV:
            begin
                if (feed)
                begin
                    num_reg <= {num_reg[ACC_W-2:0], 1'b0};
                end
                rem_reg <= ge ? rem_sh - div_reg : rem_sh;
                q_reg   <= {q_reg[COEF_W-2:0], ge};
                ovf_reg <= ovf_reg | q_reg[COEF_W-1];
            end
            default: ;
        endcase
    end

    assign coef.ready = ready_reg;
    assign coef.c3    = c3_reg;
    assign coef.c4    = c4_reg;

endmodule
`default_nettype wire

>>> hdl/qte_horner_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_horner_step
// One Horner step in two stages: split multiply by t, then rounding,
// magnitude saturation and saturating add of the next coefficient.
// ----------------------------------------------------------------------------
module qte_horner_step #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                               clk,
    input  logic                               en_a,
    input  logic                               en_b,
    input  logic signed [qte_pkg::ACC_W-1:0]   acc_in,
    input  logic                               sat_in,
    input  logic        [qte_pkg::TIME_W-1:0]  t_in,
    input  logic signed [qte_pkg::ACC_W-1:0]   coef,
    output logic signed [qte_pkg::ACC_W-1:0]   acc_out,
    output logic                               sat_out,
    output logic        [qte_pkg::TIME_W-1:0]  t_out
);
    import qte_pkg::*;

    localparam int HI_W = 32 + TIME_W;
    localparam int LO_W = HI_W + 1;
    localparam int S    = 32 - FRACTION_BITS;
    localparam logic [LO_W-1:0]  HALF   = LO_W'(1) << (FRACTION_BITS - 1);
    localparam logic [ACC_W-1:0] HI_LIM = MAG_MAX >> S;

    logic [ACC_W-1:0]        m_in;
    logic [HI_W-1:0]         hi_reg;
    logic [LO_W-1:0]         lo_reg;
    logic                    neg_reg;
    logic                    sat_a_reg;
    logic [TIME_W-1:0]       t_a_reg;

    logic [ACC_W-1:0]        hi_ext;
    logic [ACC_W-1:0]        q;
    logic [ACC_W-1:0]        x;
    logic                    ovf_mul;
    logic [ACC_W-1:0]        mag;
    logic [ACC_W-1:0]        prod;
    logic [ACC_W:0]          sum;
    logic                    ovf_add;
    logic [ACC_W-1:0]        res;

    logic signed [ACC_W-1:0] acc_reg;
    logic                    sat_reg;
    logic [TIME_W-1:0]       t_reg;

    assign m_in = mag64(acc_in);

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            hi_reg    <= m_in[ACC_W-1:32] * t_in;
            lo_reg    <= LO_W'(m_in[31:0] * t_in) + HALF;
            neg_reg   <= acc_in[ACC_W-1];
            sat_a_reg <= sat_in;
            t_a_reg   <= t_in;
        end
    end

    assign hi_ext  = ACC_W'(hi_reg);
    assign q       = hi_ext << S;
    assign x       = ACC_W'(lo_reg >> FRACTION_BITS);
    assign ovf_mul = (hi_ext > HI_LIM) || (x > (MAG_MAX - q));
    assign mag     = ovf_mul ? MAG_MAX : q + x;
    assign prod    = neg_reg ? (~mag + 64'd1) : mag;
    assign sum     = {prod[ACC_W-1], prod} + {coef[ACC_W-1], coef};
    assign ovf_add = sum[ACC_W] != sum[ACC_W-1];
    assign res     = ovf_add ? (sum[ACC_W] ? ACC_MIN : MAG_MAX) : sum[ACC_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            acc_reg <= $signed(res);
            sat_reg <= sat_a_reg | ovf_mul | ovf_add;
            t_reg   <= t_a_reg;
        end
    end

    assign acc_out = acc_reg;
    assign sat_out = sat_reg;
    assign t_out   = t_reg;

endmodule
`default_nettype wire

>>> hdl/qte_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qte_lane
// One derivative: four Horner steps and a final round and clamp to Q.F.
// ----------------------------------------------------------------------------
module qte_lane #(
    parameter int FRACTION_BITS = 16,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                              clk,
    input  qte_pkg::stage_en_t                en,
    input  logic [qte_pkg::TIME_W-1:0]        sample_time,
    input  qte_pkg::coef_set_t                coefs,
    output logic [qte_pkg::FIELD_W-1:0]       value,
    output logic                              saturated
);
    import qte_pkg::*;

    localparam logic [ACC_W:0] HALF  = (ACC_W + 1)'(1) << (FRACTION_BITS - 1);
    localparam logic [ACC_W:0] LIMIT = (ACC_W + 1)'(1) << (VALUE_WIDTH - 1);

    logic signed [ACC_W-1:0] acc_w [NUM_TERMS];
    logic                    sat_w [NUM_TERMS];
    logic [TIME_W-1:0]       t_w   [NUM_TERMS];

    assign acc_w[0] = $signed(coefs[0]);
    assign sat_w[0] = 1'b0;
    assign t_w[0]   = sample_time;

    for (genvar k = 0; k < NUM_STEPS; k++)
    begin : g_step
        qte_horner_step #(
            .FRACTION_BITS(FRACTION_BITS)
        ) u_step (
            .clk    (clk),
            .en_a   (en[2*k]),
            .en_b   (en[2*k+1]),
            .acc_in (acc_w[k]),
            .sat_in (sat_w[k]),
            .t_in   (t_w[k]),
            .coef   ($signed(coefs[k+1])),
            .acc_out(acc_w[k+1]),
            .sat_out(sat_w[k+1]),
            .t_out  (t_w[k+1])
        );
    end

    logic                    neg;
    logic [ACC_W:0]          rq;
    logic [ACC_W:0]          lim;
    logic                    clip;
    logic [ACC_W:0]          qc;
    logic [ACC_W:0]          sv;
    logic [FIELD_W-1:0]      value_reg;
    logic                    sat_reg;

    assign neg  = acc_w[NUM_STEPS][ACC_W-1];
    assign rq   = ((ACC_W + 1)'(mag64(acc_w[NUM_STEPS])) + HALF) >> FRACTION_BITS;
    assign lim  = neg ? LIMIT : LIMIT - 1'b1;
    assign clip = rq > lim;
    assign qc   = clip ? lim : rq;
    assign sv   = neg ? (~qc + 1'b1) : qc;

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES-1])
        begin
            value_reg <= sv[FIELD_W-1:0];
            sat_reg   <= sat_w[NUM_STEPS] | clip;
        end
    end

    assign value     = value_reg;
    assign saturated = sat_reg;

endmodule
`default_nettype wire

>>> test/quartic_trajectory_evaluator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quartic_trajectory_evaluator_checker
// Watches the register port and both channels of the evaluator. It keeps its
// own copy of the boundary conditions, predicts each sample's position,
// velocity, acceleration, jerk and flags, and compares them in order.
// ----------------------------------------------------------------------------
module quartic_trajectory_evaluator_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [qte_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qte_pkg::FIELD_W-1:0]        cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [qte_pkg::TIME_W-1:0]         sample_time,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [qte_pkg::FIELD_W-1:0] position,
    input  logic signed [qte_pkg::FIELD_W-1:0] velocity,
    input  logic signed [qte_pkg::FIELD_W-1:0] acceleration,
    input  logic signed [qte_pkg::FIELD_W-1:0] jerk,
    input  logic                               saturated,
    input  logic                               invalid_duration,
    output int                                 failures,
    output int                                 pending,
    output int                                 checked,
    output int                                 saturated_seen
);
    import qte_pkg::*;

    localparam int FRAC = 16;

    typedef struct packed {
        logic [FIELD_W-1:0] pos;
        logic [FIELD_W-1:0] vel;
        logic [FIELD_W-1:0] acc;
        logic [FIELD_W-1:0] jrk;
        logic               sat;
        logic               inv;
    } motion_sample_t;

    motion_sample_t expected_samples[$];

    longint          p0, v0, a0, ve, ae;
    logic [TIME_W-1:0] dur;

    function automatic logic [63:0] magnitude(input longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint solve_coef(input longint n, input int sh,
                                          input logic [127:0] d);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] rem;
        num = {64'd0, magnitude(n)} << sh;
        q = num / d;
        rem = num - q * d;
        if ((rem << 1) >= d)
            q = q + 1;
        if (q > {80'd0, COEF_MAX})
            q = {80'd0, COEF_MAX};
        return n < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint scale_by_time(input longint a, input logic [TIME_W-1:0] t,
                                             inout logic sat);
        logic [127:0] p;
        p = ({64'd0, magnitude(a)} * t + (128'd1 << (FRAC - 1))) >> FRAC;
        if (p > {64'd0, MAG_MAX})
        begin
            sat = 1'b1;
            p = {64'd0, MAG_MAX};
        end
        return a < 0 ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint add_clamped(input longint a, input longint b, inout logic sat);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7fff_ffff_ffff_ffff)
        begin
            sat = 1'b1;
            return 64'sh7fff_ffff_ffff_ffff;
        end
        if (s < -65'sh0_8000_0000_0000_0000)
        begin
            sat = 1'b1;
            return 64'sh8000_0000_0000_0000;
        end
        return longint'(s[63:0]);
    endfunction

    function automatic logic [FIELD_W-1:0] evaluate(input longint c[5], input int n,
                                                   input logic [TIME_W-1:0] t,
                                                   inout logic sat);
        longint      a;
        logic [63:0] q;
        logic [63:0] lim;
        a = c[0];
        for (int i = 1; i < n; i++)
            a = add_clamped(scale_by_time(a, t, sat), c[i], sat);
        q = (magnitude(a) + (64'd1 << (FRAC - 1))) >> FRAC;
        lim = (64'd1 << (FIELD_W - 1)) - (a < 0 ? 64'd0 : 64'd1);
        if (q > lim)
        begin
            q = lim;
            sat = 1'b1;
        end
        return a < 0 ? FIELD_W'(-q) : FIELD_W'(q);
    endfunction

    function automatic motion_sample_t predict_sample(input logic [TIME_W-1:0] t);
        motion_sample_t r;
        longint         tq, b0, b1, n3, n4, c2, c3, c4;
        logic [127:0]   t3;
        longint         cp[5], cv[5], ca[5], cj[5];
        logic           sat;
        r = '0;
        if (dur == 0)
        begin
            r.inv = 1'b1;
            return r;
        end
        tq = longint'(dur);
        b0 = (ve - v0) * (longint'(1) << FRAC) - a0 * tq;
        b1 = ae - a0;
        n3 = 3 * b0 - tq * b1;
        n4 = tq * b1 - 2 * b0;
        t3 = 128'(dur) * dur * dur;
        c3 = solve_coef(n3, 2 * FRAC, 128'(3) * dur * dur);
        c4 = solve_coef(n4, 3 * FRAC, t3 << 2);
        c2 = a0 * (longint'(1) << (FRAC - 1));
        cp = '{c4, c3, c2, v0 * (longint'(1) << FRAC), p0 * (longint'(1) << FRAC)};
        cv = '{4 * c4, 3 * c3, 2 * c2, v0 * (longint'(1) << FRAC), 0};
        ca = '{12 * c4, 6 * c3, 2 * c2, 0, 0};
        cj = '{24 * c4, 6 * c3, 0, 0, 0};
        sat = 1'b0;
        r.pos = evaluate(cp, 5, t, sat);
        r.vel = evaluate(cv, 4, t, sat);
        r.acc = evaluate(ca, 3, t, sat);
        r.jrk = evaluate(cj, 2, t, sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic report(input string what, input logic [FIELD_W-1:0] exp_v,
                          input logic [FIELD_W-1:0] act_v);
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        motion_sample_t e;
        if (!rst_n)
        begin
            p0 = 0; v0 = 0; a0 = 0; ve = 0; ae = 0;
            dur = DURATION_RESET;
            expected_samples.delete();
            failures = 0;
            pending = 0;
            checked = 0;
            saturated_seen = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_START_POSITION:     p0 = longint'(signed'(cfg_data));
                    REG_START_VELOCITY:     v0 = longint'(signed'(cfg_data));
                    REG_START_ACCELERATION: a0 = longint'(signed'(cfg_data));
                    REG_END_VELOCITY:       ve = longint'(signed'(cfg_data));
                    REG_END_ACCELERATION:   ae = longint'(signed'(cfg_data));
                    REG_DURATION:           dur = cfg_data[TIME_W-1:0];
                    default:                ;
                endcase
            end
            if (in_valid && in_ready)
                expected_samples.insert(expected_samples.size(), predict_sample(sample_time));
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual %h %h %h %h",
                             $time, position, velocity, acceleration, jerk);
                    failures++;
                end
                else
                begin
                    e = expected_samples.pop_front();
                    checked++;
                    if (e.sat)
                        saturated_seen++;
                    if (position !== e.pos) report("position", e.pos, position);
                    if (velocity !== e.vel) report("velocity", e.vel, velocity);
                    if (acceleration !== e.acc) report("acceleration", e.acc, acceleration);
                    if (jerk !== e.jrk) report("jerk", e.jrk, jerk);
                    if (saturated !== e.sat)
                        report("saturated", FIELD_W'(e.sat), FIELD_W'(saturated));
                    if (invalid_duration !== e.inv)
                        report("invalid_duration", FIELD_W'(e.inv), FIELD_W'(invalid_duration));
                end
            end
            pending = expected_samples.size();
        end
    end

endmodule

>>> test/quartic_trajectory_evaluator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quartic_trajectory_evaluator_test
// Drives register settings and sample times into the evaluator, from typical
// profiles to extreme and zero durations, with random gaps on both channels
// and one long output stall; a checker compares every transaction.
// ----------------------------------------------------------------------------
module quartic_trajectory_evaluator_test;
    import qte_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [FIELD_W-1:0]        cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [TIME_W-1:0]         sample_time;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [FIELD_W-1:0] position;
    logic signed [FIELD_W-1:0] velocity;
    logic signed [FIELD_W-1:0] acceleration;
    logic signed [FIELD_W-1:0] jerk;
    logic                      saturated;
    logic                      invalid_duration;

    int failures, pending, checked, saturated_seen;
    int stall_cycles = 0;
    int phases;
    bit calm;
    bit long_hold;
    logic [TIME_W-1:0] cur_dur;

    quartic_trajectory_evaluator dut (.*);

    quartic_trajectory_evaluator_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d transactions outstanding", $time, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_sample(input logic [TIME_W-1:0] t);
        sample_time <= t;
        in_valid <= 1'b1;
        forever
        begin
            #1;
            if (in_ready)
                break;
            @(negedge clk);
        end
        @(posedge clk);
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
    endtask

    task automatic load_profile(input logic [FIELD_W-1:0] sp, input logic [FIELD_W-1:0] sv,
                                input logic [FIELD_W-1:0] sa, input logic [FIELD_W-1:0] ev,
                                input logic [FIELD_W-1:0] ea, input logic [TIME_W-1:0] t);
        write_reg(REG_START_POSITION, sp);
        write_reg(REG_START_VELOCITY, sv);
        write_reg(REG_START_ACCELERATION, sa);
        write_reg(REG_END_VELOCITY, ev);
        write_reg(REG_END_ACCELERATION, ea);
        write_reg(REG_DURATION, {8'd0, t});
        cfg_write <= 1'b0;
        cur_dur = t;
        @(negedge clk);
    endtask

    function automatic logic [FIELD_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return FIELD_W'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
            2:       return FIELD_W'($signed($urandom_range(0, 2 * 65536)) - 65536);
            default: return FIELD_W'($signed($urandom_range(0, 2 * 4096)) - 4096);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        if (cur_dur != 0 && $urandom_range(0, 3) != 0)
            return TIME_W'($urandom_range(0, cur_dur));
        return TIME_W'($urandom);
    endfunction

    task automatic run_phase(input bit directed, input int count);
        if (directed)
        begin
            send_sample('0);
            send_sample(cur_dur);
            send_sample(cur_dur >> 1);
            send_sample('1);
        end
        repeat (count) send_sample(rand_time());
        drain();
        phases++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_time = '0;
        calm = 1'b0;
        long_hold = 1'b0;
        phases = 0;
        cur_dur = DURATION_RESET;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_phase(1'b1, 40);

        load_profile(32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0002_0000, 32'h0, 24'h02_0000);
        long_hold = 1'b1;
        run_phase(1'b1, 60);

        load_profile(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 24'hff_ffff);
        run_phase(1'b1, 25);

        load_profile(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000_0000, 24'h00_0001);
        run_phase(1'b1, 25);

        load_profile(32'h0003_0000, 32'hffff_0000, 32'h0000_4000, 32'h0, 32'h0, 24'h0);
        run_phase(1'b1, 25);

        repeat (7)
        begin
            load_profile(rand_value(), rand_value(), rand_value(), rand_value(), rand_value(),
                         $urandom_range(0, 9) == 0 ? TIME_W'($urandom)
                                                   : TIME_W'($urandom_range(1, 6 * 65536)));
            run_phase(1'b0, 45);
        end

        calm = 1'b1;
        load_profile(rand_value(), rand_value(), rand_value(), rand_value(), rand_value(),
                     TIME_W'($urandom_range(4096, 4 * 65536)));
        run_phase(1'b0, 45);

        $display("Covered %0d register settings, %0d samples checked, %0d saturated.",
                 phases, checked, saturated_seen);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
